// File: hdl/iubs_pkg.sv
// Shared constants, types and helpers of the integrated uniform B-spline evaluator.
package iubs_pkg;

    localparam int MAX_ORDER = 7;
    localparam int FRAC      = 24;
    localparam int VW        = FRAC + 1;
    localparam int NCELL     = 2 * MAX_ORDER + 4;
    localparam int IDXW      = $clog2(NCELL);
    localparam int KW        = $clog2(MAX_ORDER + 2);
    localparam int LVLW      = $clog2(MAX_ORDER + 3);
    localparam int DW        = 30;
    localparam int RW        = 30;
    localparam int RSH       = 29;
    localparam int XW        = 19;
    localparam int ACCW      = 28;
    localparam int OW        = 17;

    localparam logic [1:0] PH_MUL = 2'd0;
    localparam logic [1:0] PH_ADD = 2'd1;
    localparam logic [1:0] PH_RCP = 2'd2;
    localparam logic [1:0] PH_FIX = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_SUM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic            load;
        logic            calc;
        logic [1:0]      ph;
        logic            shift;
        logic [LVLW-1:0] lvl;
        logic [IDXW-1:0] top;
        logic [2:0]      seg;
        logic [26:0]     x24;
        logic [3:0]      dv;
        logic [RW-1:0]   recip;
    } cell_ctl_t;

    function automatic logic [RW-1:0] recip_of(input logic [3:0] d);
        logic [RW-1:0] r;
        case (d)
            4'd1:    r = 30'd536870912;
            4'd2:    r = 30'd268435456;
            4'd3:    r = 30'd178956970;
            4'd4:    r = 30'd134217728;
            4'd5:    r = 30'd107374182;
            4'd6:    r = 30'd89478485;
            4'd7:    r = 30'd76695844;
            4'd8:    r = 30'd67108864;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/iubs_cell.sv
// One basis cell: holds one B-spline value and updates it from its right neighbour.
module iubs_cell (
    input  logic                           aclk,
    input  logic [iubs_pkg::IDXW-1:0]      idx,
    input  iubs_pkg::cell_ctl_t            ctl,
    input  logic [iubs_pkg::VW-1:0]        nb,
    output logic [iubs_pkg::VW-1:0]        val
);

    logic [iubs_pkg::VW-1:0] val_reg, val_next;
    logic [iubs_pkg::DW-1:0] pa_reg, pb_reg;
    logic [iubs_pkg::DW:0]   n_reg;
    logic [28:0]             q_reg;
    logic [iubs_pkg::DW-1:0] x24w, lo, hi, dl, dr;
    logic [54:0]             pa_full, pb_full;
    logic [58:0]             qp;
    logic [32:0]             qd;
    logic [32:0]             rem;
    logic                    active;

    always_comb begin
        x24w    = {3'b0, ctl.x24};
        lo      = iubs_pkg::DW'(idx) << iubs_pkg::FRAC;
        hi      = iubs_pkg::DW'(6'(idx) + 6'(ctl.lvl)) << iubs_pkg::FRAC;
        dl      = (x24w > lo) ? (x24w - lo) : '0;
        dr      = (hi > x24w) ? (hi - x24w) : '0;
        pa_full = 55'(dl) * 55'(val_reg);
        pb_full = 55'(dr) * 55'(nb);
        qp      = 59'(n_reg[28:0]) * 59'(ctl.recip);
        qd      = 33'(q_reg) * 33'(ctl.dv);
        rem     = 33'(n_reg) - qd;
        active  = (idx <= ctl.top);
        val_next = val_reg;
        if (ctl.load) begin
            val_next = (idx == iubs_pkg::IDXW'(ctl.seg)) ?
                       (iubs_pkg::VW'(1) << iubs_pkg::FRAC) : '0;
        end else if (ctl.shift) begin
            val_next = nb;
        end else if (ctl.calc && ctl.ph == iubs_pkg::PH_FIX) begin
            if (!active) begin
                val_next = '0;
            end else if (rem >= 33'(ctl.dv)) begin
                val_next = iubs_pkg::VW'(q_reg + 29'd1);
            end else begin
                val_next = iubs_pkg::VW'(q_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        if (ctl.calc && ctl.ph == iubs_pkg::PH_MUL) begin
            pa_reg <= pa_full[53:24];
            pb_reg <= pb_full[53:24];
        end
        if (ctl.calc && ctl.ph == iubs_pkg::PH_ADD) begin
            n_reg <= 31'(pa_reg) + 31'(pb_reg);
        end
        if (ctl.calc && ctl.ph == iubs_pkg::PH_RCP) begin
            q_reg <= qp[57:29];
        end
    end

    assign val = val_reg;

endmodule

// File: hdl/iubs_ctrl.sv
// Sequencer: input handshake, level and phase stepping, final sum and result register.
module iubs_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [iubs_pkg::XW-1:0]     x_in,
    input  logic [2:0]                  order,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [iubs_pkg::OW-1:0]     res_out,
    input  logic [iubs_pkg::VW-1:0]     val0,
    output iubs_pkg::cell_ctl_t         ctl
);

    iubs_pkg::state_t              state_reg, state_next;
    logic [iubs_pkg::XW-1:0]       x_reg, x_next;
    logic [iubs_pkg::KW-1:0]       k_reg, k_next, kk;
    logic [iubs_pkg::LVLW-1:0]     lvl_reg, lvl_next;
    logic [1:0]                    ph_reg, ph_next;
    logic [iubs_pkg::KW-1:0]       cnt_reg, cnt_next;
    logic [iubs_pkg::ACCW-1:0]     acc_reg, acc_next, acc_sum;
    logic [iubs_pkg::OW-1:0]       res_reg, res_next;
    logic [iubs_pkg::OW-1:0]       mout_reg, mout_next;
    logic                          mvalid_reg, mvalid_next;
    logic [iubs_pkg::ACCW:0]       rnd;
    logic [2:0]                    ord_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= iubs_pkg::ST_IDLE;
            mvalid_reg <= 1'b0;
            lvl_reg    <= '0;
            ph_reg     <= '0;
            cnt_reg    <= '0;
            k_reg      <= '0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            lvl_reg    <= lvl_next;
            ph_reg     <= ph_next;
            cnt_reg    <= cnt_next;
            k_reg      <= k_next;
        end
        x_reg    <= x_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        mout_reg <= mout_next;
    end

    always_comb begin
        state_next  = state_reg;
        x_next      = x_reg;
        k_next      = k_reg;
        lvl_next    = lvl_reg;
        ph_next     = ph_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        res_next    = res_reg;
        mout_next   = mout_reg;
        mvalid_next = mvalid_reg && !m_tready;
        s_tready    = 1'b0;
        ord_c       = (32'(order) > iubs_pkg::MAX_ORDER) ? 3'(iubs_pkg::MAX_ORDER) : order;
        kk          = iubs_pkg::KW'(ord_c) + iubs_pkg::KW'(1);
        acc_sum     = acc_reg + iubs_pkg::ACCW'(val0);
        rnd         = (iubs_pkg::ACCW+1)'(acc_sum) + (iubs_pkg::ACCW+1)'(128);
        ctl         = '0;
        ctl.lvl     = lvl_reg;
        ctl.ph      = ph_reg;
        ctl.x24     = {x_reg, 8'b0};
        ctl.top     = iubs_pkg::IDXW'(6'(k_reg) * 6'd2 + 6'd1 - 6'(lvl_reg));
        ctl.dv      = 4'(lvl_reg) - 4'd1;
        ctl.recip   = iubs_pkg::recip_of(4'(lvl_reg) - 4'd1);
        ctl.seg     = x_in[18:16];

        case (state_reg)
            iubs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    x_next = x_in;
                    k_next = kk;
                    if (x_in == '0) begin
                        res_next   = '0;
                        state_next = iubs_pkg::ST_DONE;
                    end else if (20'(x_in) >= (20'(kk) << 16)) begin
                        res_next   = iubs_pkg::OW'(65536);
                        state_next = iubs_pkg::ST_DONE;
                    end else begin
                        ctl.load   = 1'b1;
                        lvl_next   = iubs_pkg::LVLW'(2);
                        ph_next    = iubs_pkg::PH_MUL;
                        state_next = iubs_pkg::ST_CALC;
                    end
                end
            end
            iubs_pkg::ST_CALC: begin
                ctl.calc = 1'b1;
                ph_next  = ph_reg + 2'd1;
                if (ph_reg == iubs_pkg::PH_FIX) begin
                    if (5'(lvl_reg) == 5'(k_reg) + 5'd1) begin
                        cnt_next   = '0;
                        acc_next   = '0;
                        state_next = iubs_pkg::ST_SUM;
                    end else begin
                        lvl_next = lvl_reg + iubs_pkg::LVLW'(1);
                    end
                end
            end
            iubs_pkg::ST_SUM: begin
                ctl.shift = 1'b1;
                acc_next  = acc_sum;
                cnt_next  = cnt_reg + iubs_pkg::KW'(1);
                if (cnt_reg == k_reg) begin
                    res_next   = (rnd[iubs_pkg::ACCW:8] > 21'd65536) ?
                                 iubs_pkg::OW'(65536) :
                                 iubs_pkg::OW'(rnd[iubs_pkg::ACCW:8]);
                    state_next = iubs_pkg::ST_DONE;
                end
            end
            iubs_pkg::ST_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    mout_next   = res_reg;
                    mvalid_next = 1'b1;
                    state_next  = iubs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = iubs_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = mvalid_reg;
    assign res_out  = mout_reg;

`ifndef SYNTHESIS
    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == iubs_pkg::ST_CALC || state_reg == iubs_pkg::ST_SUM) |-> !s_tready)
        else $error("input taken while busy");
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg != iubs_pkg::ST_IDLE)
        else $error("accepted item lost");
    a_lvl_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == iubs_pkg::ST_CALC) |->
        (lvl_reg >= iubs_pkg::LVLW'(2) && 5'(lvl_reg) <= 5'(k_reg) + 5'd1))
        else $error("level out of range");
    a_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == iubs_pkg::ST_SUM) |-> cnt_reg <= k_reg)
        else $error("sum count overrun");
    a_result_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res_out <= iubs_pkg::OW'(65536))
        else $error("result above one");
`endif

endmodule

// File: hdl/integrated_uniform_bspline_eval_top.sv
// Top level of the integrated uniform B-spline evaluator: order register, cell row, sequencer.
// For each item (k = spline_order + 1) the sequencer steps k recurrence levels of four
// phases each (products, add, reciprocal multiply, correction) in every cell of the row at once,
// then shifts k+1 values out of the row into the accumulator. Abscissae of zero or at/past k
// skip the recurrence and go straight to the result register. One item is in work at a time; a
// finished result waits in the output register while the next item is taken.
module integrated_uniform_bspline_eval_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,      // spline_order
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,        // [18:0] x_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata         // [16:0] cumulative_value
);

    logic [2:0]                   order_reg;
    iubs_pkg::cell_ctl_t          ctl;
    logic [iubs_pkg::VW-1:0]      vals [iubs_pkg::NCELL];
    logic [iubs_pkg::OW-1:0]      res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= 3'd3;
        end else if (cfg_we) begin
            order_reg <= cfg_wdata;
        end
    end

    iubs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .x_in     (s_tdata[iubs_pkg::XW-1:0]),
        .order    (order_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_out  (res),
        .val0     (vals[0]),
        .ctl      (ctl)
    );

    for (genvar g = 0; g < iubs_pkg::NCELL; g++) begin : g_cell
        logic [iubs_pkg::VW-1:0] nb;
        if (g == iubs_pkg::NCELL - 1) begin : g_last
            assign nb = '0;
        end else begin : g_mid
            assign nb = vals[g+1];
        end
        iubs_cell u_cell (
            .aclk (aclk),
            .idx  (iubs_pkg::IDXW'(g)),
            .ctl  (ctl),
            .nb   (nb),
            .val  (vals[g])
        );
    end

    assign m_tdata = {7'b0, res};

endmodule

// File: tb/sv/iubs_checker.sv
// Checker: watches both channels, predicts the cumulative spline value and compares.
module iubs_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [2:0]  order_reg;
    logic [16:0] expected_values[$];

    function automatic logic [16:0] cumulative_of(input logic [18:0] x16, input logic [2:0] ord);
        logic [63:0] basis[0:iubs_pkg::NCELL-1];
        logic [63:0] x24, lo, hi, dl, dr, a, b, sum, r;
        int k, seg, top;
        k = int'(ord) + 1;
        if (x16 == 0) return 17'd0;
        if (x16 >= (k << 16)) return 17'd65536;
        x24 = 64'(x16) << 8;
        seg = int'(x16 >> 16);
        for (int i = 0; i < iubs_pkg::NCELL; i++) basis[i] = 0;
        if (seg <= 2 * k) basis[seg] = 64'd1 << 24;
        for (int lvl = 2; lvl <= k + 1; lvl++) begin
            top = 2 * k + 1 - lvl;
            for (int i = 0; i <= top; i++) begin
                lo = 64'(i) << 24;
                hi = 64'(i + lvl) << 24;
                dl = (x24 > lo) ? x24 - lo : 0;
                dr = (hi > x24) ? hi - x24 : 0;
                a = (dl * basis[i]) >> 24;
                b = (dr * basis[i+1]) >> 24;
                basis[i] = (a + b) / 64'(lvl - 1);
            end
            basis[top+1] = 0;
        end
        sum = 0;
        for (int i = 0; i <= k; i++) sum += basis[i];
        r = (sum + 128) >> 8;
        if (r > 65536) r = 65536;
        return r[16:0];
    endfunction

    assign pending = expected_values.size();

    always @(posedge aclk) begin
        logic [16:0] want;
        if (!aresetn) begin
            order_reg <= 3'd3;
            fail_count <= 0;
        end else begin
            if (cfg_we) order_reg <= cfg_wdata;
            if (s_tvalid && s_tready)
                expected_values.push_back(cumulative_of(s_tdata[18:0], order_reg));
            if (m_tvalid && m_tready) begin
                if (expected_values.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %0d", $time,
                             m_tdata[16:0]);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_values.pop_front();
                    if (m_tdata[16:0] !== want) begin
                        $display("%0t: cumulative_value expected %0d actual %0d", $time,
                                 want, m_tdata[16:0]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: tb/sv/testbench.sv
// Testbench top: clock, reset, configuration phases, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_wdata = 3'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = 24'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    int          fail_count;
    int          pending;
    int          hold_off = 0;
    int          ready_mode = 0;
    logic [2:0]  order_now = 3'd3;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    integrated_uniform_bspline_eval_top uut (.*);

    iubs_checker chk (.*);

    always @(posedge aclk) begin
        if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (ready_mode == 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_x(input logic [18:0] x);
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic gap_maybe(inout int burst);
        if (burst > 0) begin
            burst--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge aclk);
            burst = $urandom_range(0, 12);
        end
    endtask

    task automatic drain_and_set(input logic [2:0] ord);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= ord;
        order_now = ord;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [18:0] pick_x(input logic [2:0] ord);
        int k;
        k = int'(ord) + 1;
        case ($urandom_range(0, 9))
            0: return 19'($urandom_range(0, 3));
            1: return 19'((k << 16) - $urandom_range(0, 2));
            2: return 19'(($urandom_range(0, 7) << 16) + $urandom_range(0, 1));
            3: return 19'($urandom);
            default: return 19'($urandom_range(0, (k << 16) - 1));
        endcase
    endfunction

    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [2:0] orders[6] = '{3'd0, 3'd7, 3'd1, 3'd5, 3'd2, 3'd6};
        int burst;
        burst = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (orders[j]) begin
            drain_and_set(orders[j]);
            ready_mode = j % 2;
            if (j == 0) begin
                send_x(19'd0); send_x(19'd1); send_x(19'h7FFFF); send_x(19'h10000);
                send_x(19'hFFFF);
                drain_and_set(3'd7);
                send_x(19'd0); send_x(19'd1); send_x(19'h7FFFF); send_x(19'h7FFFE);
                send_x(19'h40000); send_x(19'h3FFFF); send_x(19'h55555); send_x(19'h2AAAA);
                send_x(19'h10000); send_x(19'h00001);
                drain_and_set(3'd3);
                send_x(19'h30000); send_x(19'h2FFFF); send_x(19'h18000); send_x(19'h08000);
                drain_and_set(orders[j]);
            end
            if (j == 2) hold_off <= 400;
            for (int n = 0; n < 100; n++) begin
                send_x(pick_x(order_now));
                gap_maybe(burst);
                if (n == 50) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (pending != 0) @(posedge aclk);
                end
            end
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
